// ===== src/rsc_pkg.sv =====
`default_nettype none
package rsc_pkg;

  localparam int unsigned NumSites = 16;
  localparam int unsigned NumVals  = 8;
  localparam int unsigned SiteW    = 4;
  localparam int unsigned ValW     = 3;
  localparam int unsigned CntW     = 5;
  localparam int unsigned LenW     = 5;
  localparam int unsigned QW       = 4;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned RngW     = 32;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRingLength = 4'd0;
  localparam logic [CfgIdxW-1:0] RegNumStates  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegRngSeed    = 4'd3;

  // Control broadcast to every site cell.
  typedef struct packed {
    logic            init;
    logic            place;
    logic            step_right;
    logic            step_left;
    logic            flip;
    logic [ValW-1:0] old_val;
    logic [ValW-1:0] new_val;
  } cell_ctl_t;

  // Effective ring length, clamped to 2..NumSites.
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] n);
    logic [LenW-1:0] r;
    r = n;
    if (n < LenW'(2)) r = LenW'(2);
    if (n > LenW'(NumSites)) r = LenW'(NumSites);
    return r;
  endfunction

  // Effective number of spin values, clamped to 2..NumVals.
  function automatic logic [QW-1:0] eff_q(input logic [QW-1:0] n);
    logic [QW-1:0] r;
    r = n;
    if (n < QW'(2)) r = QW'(2);
    if (n > QW'(NumVals)) r = QW'(NumVals);
    return r;
  endfunction

  // Site number reduced modulo the ring length by shifted compare and subtract.
  function automatic logic [SiteW-1:0] site_mod(input logic [SiteW-1:0] s,
                                                input logic [LenW-1:0] len);
    logic [SiteW+LenW-1:0] r;
    logic [SiteW+LenW-1:0] d;
    r = (SiteW+LenW)'(s);
    for (int k = SiteW - 1; k >= 0; k--) begin
      d = (SiteW+LenW)'(len) << k;
      if (r >= d) r = r - d;
    end
    return r[SiteW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/ring_spin_cluster_flip.sv =====
`default_nettype none
// A transaction is accepted only while idle; the seed flip, the walk right and left
// and the count update follow in turn, then the result strobe. busy_o is low again in
// the strobe cycle. The walk token takes one site per cycle, and no new seed is taken
// before the result. The receiver cannot stall: each result strobe lasts one cycle only.
// Reset: all spins zero, the whole ring counted under value zero, generator at its seed.
module ring_spin_cluster_flip (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [rsc_pkg::SiteW-1:0]     seed_site_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rsc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rsc_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                               done_o,
  output logic [rsc_pkg::SiteW-1:0]          cluster_start_o,
  output logic [rsc_pkg::LenW-1:0]           cluster_length_o,
  output logic [rsc_pkg::ValW-1:0]           old_value_o,
  output logic [rsc_pkg::ValW-1:0]           new_value_o,
  output logic [rsc_pkg::CntW-1:0]           old_value_count_o,
  output logic [rsc_pkg::CntW-1:0]           new_value_count_o
);
  import rsc_pkg::*;

  // Sequencer states. The seed is flipped first, then the token walks right,
  // is placed left of the seed and walks left, and the counts are settled.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSeed  = 3'd1;
  localparam logic [2:0] StRight = 3'd2;
  localparam logic [2:0] StLeft  = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [LenW-1:0]  ring_len_q, ring_len_d;
  logic [QW-1:0]    num_states_q, num_states_d;
  logic [ThrW-1:0]  thr_q, thr_d;
  logic [RngW-1:0]  rng_seed_q, rng_seed_d;
  logic             geom_init;
  logic             rng_load;

  // Per-item working registers.
  logic [SiteW-1:0] s_q, s_d;
  logic [ValW-1:0]  old_q, old_d;
  logic [ValW-1:0]  new_q, new_d;
  logic [LenW-1:0]  right_q, right_d;
  logic [LenW-1:0]  left_q, left_d;

  logic [CntW-1:0]  counts_q [NumVals];
  logic [CntW-1:0]  counts_d [NumVals];

  logic             done_q, done_d;
  logic [SiteW-1:0] start_q, start_d;
  logic [LenW-1:0]  length_q, length_d;
  logic [CntW-1:0]  old_cnt_q, old_cnt_d;
  logic [CntW-1:0]  new_cnt_q, new_cnt_d;

  // Cell row wiring.
  cell_ctl_t           ctl;
  logic [NumSites-1:0] place_vec;
  logic [NumSites-1:0] tok_w;
  logic [NumSites-1:0] hit_w;
  logic [NumSites-1:0] tok_lower;
  logic [NumSites-1:0] tok_upper;
  logic [ValW-1:0]     spin_w [NumSites];

  logic             hit_any;
  logic             rng_step;
  logic             rng_join;
  logic [LenW-1:0]  len;
  logic [QW-1:0]    q;
  logic [SiteW-1:0] s_mod;
  logic [SiteW-1:0] s_right;
  logic [SiteW-1:0] s_left;
  logic [ValW-1:0]  seed_val;
  logic [LenW-1:0]  total;
  logic [LenW:0]    wrap_start;

  assign len     = eff_len(ring_len_q);
  assign q       = eff_q(num_states_q);
  assign hit_any = |hit_w;

  // Configuration writes are always taken. Any known register reloads the
  // generator; a geometry register also clears the ring.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ring_len_d   = ring_len_q;
    num_states_d = num_states_q;
    thr_d        = thr_q;
    rng_seed_d   = rng_seed_q;
    geom_init    = 1'b0;
    rng_load     = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRingLength: begin
          ring_len_d = cfg_data_i[LenW-1:0];
          geom_init  = 1'b1;
          rng_load   = 1'b1;
        end
        RegNumStates: begin
          num_states_d = cfg_data_i[QW-1:0];
          geom_init    = 1'b1;
          rng_load     = 1'b1;
        end
        RegThreshold: begin
          thr_d    = cfg_data_i[ThrW-1:0];
          rng_load = 1'b1;
        end
        RegRngSeed: begin
          rng_seed_d = cfg_data_i[RngW-1:0];
          rng_load   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Ring neighbours: the site at the end of the used ring wraps to site zero,
  // and cells beyond the used ring never receive the token.
  always_comb begin
    for (int i = 0; i < NumSites; i++) begin
      if (i == 0) begin
        tok_lower[i] = tok_w[len[SiteW-1:0] - SiteW'(1)];
      end else if (LenW'(i) < len) begin
        tok_lower[i] = tok_w[(i + NumSites - 1) % NumSites];
      end else begin
        tok_lower[i] = 1'b0;
      end
      if (LenW'(i) == len - LenW'(1)) begin
        tok_upper[i] = tok_w[0];
      end else if (LenW'(i + 1) < len) begin
        tok_upper[i] = tok_w[(i+1) % NumSites];
      end else begin
        tok_upper[i] = 1'b0;
      end
    end
  end

  assign s_mod    = site_mod(seed_site_i, len);
  assign seed_val = spin_w[s_mod];
  assign s_right  = (LenW'(s_q) + LenW'(1) == len) ? '0 : s_q + SiteW'(1);
  assign s_left   = (s_q == '0) ? SiteW'(len - LenW'(1)) : s_q - SiteW'(1);
  assign total    = LenW'(1) + right_q + left_q;
  assign wrap_start = (LenW+1)'(s_q) + (LenW+1)'(len) - (LenW+1)'(left_q);

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    old_d       = old_q;
    new_d       = new_q;
    right_d     = right_q;
    left_d      = left_q;
    done_d      = 1'b0;
    start_d     = start_q;
    length_d    = length_q;
    old_cnt_d   = old_cnt_q;
    new_cnt_d   = new_cnt_q;
    rng_step    = 1'b0;
    place_vec   = '0;
    ctl.init       = geom_init;
    ctl.place      = 1'b0;
    ctl.step_right = 1'b0;
    ctl.step_left  = 1'b0;
    ctl.flip       = 1'b0;
    ctl.old_val    = old_q;
    ctl.new_val    = new_q;
    for (int k = 0; k < NumVals; k++) counts_d[k] = counts_q[k];

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          ctl.place = 1'b1;
          place_vec = NumSites'(1) << s_mod;
          s_d       = s_mod;
          old_d     = seed_val;
          new_d     = ((QW'(seed_val) + QW'(1)) == q) ? '0 : seed_val + ValW'(1);
          right_d   = '0;
          left_d    = '0;
          state_d   = StSeed;
        end
      end
      StSeed: begin
        ctl.flip  = 1'b1;
        ctl.place = 1'b1;
        place_vec = NumSites'(1) << s_right;
        state_d   = StRight;
      end
      StRight: begin
        rng_step = hit_any;
        if (hit_any && rng_join) begin
          ctl.flip       = 1'b1;
          ctl.step_right = 1'b1;
          right_d        = right_q + LenW'(1);
        end else begin
          ctl.place = 1'b1;
          place_vec = NumSites'(1) << s_left;
          state_d   = StLeft;
        end
      end
      StLeft: begin
        rng_step = hit_any;
        if (hit_any && rng_join) begin
          ctl.flip      = 1'b1;
          ctl.step_left = 1'b1;
          left_d        = left_q + LenW'(1);
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        // The whole cluster moved from the old value to the new one.
        old_cnt_d        = counts_q[old_q] - CntW'(total);
        new_cnt_d        = counts_q[new_q] + CntW'(total);
        counts_d[old_q]  = old_cnt_d;
        counts_d[new_q]  = new_cnt_d;
        length_d         = total;
        if (total >= len) begin
          start_d = s_q;
        end else if (wrap_start >= (LenW+1)'(len)) begin
          start_d = SiteW'(wrap_start - (LenW+1)'(len));
        end else begin
          start_d = SiteW'(wrap_start);
        end
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (geom_init) begin
      for (int k = 0; k < NumVals; k++) counts_d[k] = '0;
      counts_d[0] = CntW'(eff_len(ring_len_d));
    end
  end

  for (genvar i = 0; i < NumSites; i++) begin : g_cell
    rsc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .place_i     (place_vec[i]),
      .tok_lower_i (tok_lower[i]),
      .tok_upper_i (tok_upper[i]),
      .spin_o      (spin_w[i]),
      .tok_o       (tok_w[i]),
      .hit_o       (hit_w[i])
    );
  end

  rsc_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (rng_load),
    .seed_i (rng_seed_d),
    .step_i (rng_step),
    .thr_i  (thr_q),
    .join_o (rng_join)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ring_len_q   <= LenW'(16);
      num_states_q <= QW'(3);
      thr_q        <= ThrW'(56174);
      rng_seed_q   <= RngW'(1);
      done_q       <= 1'b0;
      for (int k = 0; k < NumVals; k++) begin
        counts_q[k] <= (k == 0) ? CntW'(NumSites) : '0;
      end
    end else begin
      state_q      <= state_d;
      ring_len_q   <= ring_len_d;
      num_states_q <= num_states_d;
      thr_q        <= thr_d;
      rng_seed_q   <= rng_seed_d;
      done_q       <= done_d;
      for (int k = 0; k < NumVals; k++) counts_q[k] <= counts_d[k];
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    old_q     <= old_d;
    new_q     <= new_d;
    right_q   <= right_d;
    left_q    <= left_d;
    start_q   <= start_d;
    length_q  <= length_d;
    old_cnt_q <= old_cnt_d;
    new_cnt_q <= new_cnt_d;
  end

  assign busy_o            = (state_q != StIdle);
  assign done_o            = done_q;
  assign cluster_start_o   = start_q;
  assign cluster_length_o  = length_q;
  assign old_value_o       = old_q;
  assign new_value_o       = new_q;
  assign old_value_count_o = old_cnt_q;
  assign new_value_count_o = new_cnt_q;

endmodule
`default_nettype wire

// ===== src/rsc_cell.sv =====
`default_nettype none
// One ring site: its spin value and the walk token, which moves to a
// neighbouring cell on each step of the cluster walk.
module rsc_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire rsc_pkg::cell_ctl_t      ctl_i,
  input  wire logic                    place_i,
  input  wire logic                    tok_lower_i,
  input  wire logic                    tok_upper_i,
  output logic [rsc_pkg::ValW-1:0]     spin_o,
  output logic                         tok_o,
  output logic                         hit_o
);
  import rsc_pkg::*;

  logic [ValW-1:0] spin_q, spin_d;
  logic            tok_q, tok_d;

  always_comb begin
    spin_d = spin_q;
    tok_d  = tok_q;
    if (ctl_i.init) begin
      spin_d = '0;
      tok_d  = 1'b0;
    end else begin
      if (ctl_i.flip && tok_q) spin_d = ctl_i.new_val;
      if (ctl_i.place) begin
        tok_d = place_i;
      end else if (ctl_i.step_right) begin
        tok_d = tok_lower_i;
      end else if (ctl_i.step_left) begin
        tok_d = tok_upper_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_q <= '0;
      tok_q  <= 1'b0;
    end else begin
      spin_q <= spin_d;
      tok_q  <= tok_d;
    end
  end

  assign spin_o = spin_q;
  assign tok_o  = tok_q;
  assign hit_o  = tok_q && (spin_q == ctl_i.old_val);

endmodule
`default_nettype wire

// ===== src/rsc_rng.sv =====
`default_nettype none
// xorshift32 generator; each step yields one draw from the upper half word.
module rsc_rng (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire logic [rsc_pkg::RngW-1:0]  seed_i,
  input  wire logic                      step_i,
  input  wire logic [rsc_pkg::ThrW-1:0]  thr_i,
  output logic                           join_o
);
  import rsc_pkg::*;

  logic [RngW-1:0] x_q, x_d;
  logic [RngW-1:0] a, b, c;

  always_comb begin
    a = x_q ^ (x_q << 13);
    b = a ^ (a >> 17);
    c = b ^ (b << 5);
    x_d = x_q;
    if (load_i) begin
      x_d = (seed_i == '0) ? RngW'(1) : seed_i;
    end else if (step_i) begin
      x_d = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= RngW'(1);
    end else begin
      x_q <= x_d;
    end
  end

  assign join_o = c[RngW-1:RngW-ThrW] < thr_i;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
  import rsc_pkg::*;

  // Generous ceiling on the run. The slowest legal run is roughly 430 transactions, some
  // with idle gaps after them, and it ends well inside this ceiling.
  localparam int unsigned CycleLimit = 200000;
  // Highest register index the port can carry. Everything above the seed register is unused.
  localparam logic [CfgIdxW-1:0] RegUnusedTop = '1;

  // One cluster update as seen on the result ports. The field order follows the port list.
  typedef struct packed {
    logic [SiteW-1:0] cl_start;
    logic [LenW-1:0]  cl_len;
    logic [ValW-1:0]  old_val;
    logic [ValW-1:0]  new_val;
    logic [CntW-1:0]  old_cnt;
    logic [CntW-1:0]  new_cnt;
  } flip_t;

  // The scoreboard keeps its own copy of the ring, the value tallies, the generator and the
  // registers. Each accepted seed is played through the cluster walk at once, and the
  // expected update is queued until the block reports it.
  class flip_scoreboard;
    logic [LenW-1:0] ring_len_reg;
    logic [QW-1:0]   q_reg;
    logic [ThrW-1:0] thr_reg;
    logic [RngW-1:0] seed_reg;
    logic [ValW-1:0] spins [NumSites];
    logic [CntW-1:0] counts [NumVals];
    logic [RngW-1:0] rng;
    flip_t           expected_flips [$];
    int unsigned     errors;

    function new();
      ring_len_reg = LenW'(16);
      q_reg        = QW'(3);
      thr_reg      = ThrW'(56174);
      seed_reg     = RngW'(1);
      errors       = 0;
      clear_ring();
      reload_rng();
    endfunction

    function int unsigned clamp_len();
      int unsigned n;
      n = ring_len_reg;
      if (n < 2) n = 2;
      if (n > NumSites) n = NumSites;
      return n;
    endfunction

    function int unsigned clamp_q();
      int unsigned n;
      n = q_reg;
      if (n < 2) n = 2;
      if (n > NumVals) n = NumVals;
      return n;
    endfunction

    // Geometry changes put every site back to value zero.
    function void clear_ring();
      foreach (spins[i]) spins[i] = '0;
      foreach (counts[i]) counts[i] = '0;
      counts[0] = CntW'(clamp_len());
    endfunction

    // A zero seed would lock xorshift at zero, so it is loaded as one.
    function void reload_rng();
      rng = (seed_reg != '0) ? seed_reg : RngW'(1);
    endfunction

    // One xorshift32 step; the upper half of the new state is the draw.
    function bit draw_joins();
      logic [RngW-1:0] x;
      x = rng;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      rng = x;
      return x[31:16] < thr_reg;
    endfunction

    function void flip_site(int unsigned site, int unsigned oldv, int unsigned newv);
      spins[site]  = ValW'(newv);
      counts[oldv] = counts[oldv] - 1'b1;
      counts[newv] = counts[newv] + 1'b1;
    endfunction

    function void apply_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegRingLength: begin
          ring_len_reg = data[LenW-1:0];
          clear_ring();
        end
        RegNumStates: begin
          q_reg = data[QW-1:0];
          clear_ring();
        end
        RegThreshold: thr_reg = data[ThrW-1:0];
        RegRngSeed: seed_reg = data[RngW-1:0];
        default: return;
      endcase
      reload_rng();
    endfunction

    // Flip the seed, grow rightwards, then leftwards, and queue the resulting update.
    function void note_seed(logic [SiteW-1:0] seed);
      int unsigned len, q, s, oldv, newv, right, left, total, j, first;
      flip_t e;
      len   = clamp_len();
      q     = clamp_q();
      s     = seed % len;
      oldv  = spins[s] % q;
      newv  = (oldv + 1) % q;
      right = 0;
      left  = 0;
      flip_site(s, oldv, newv);
      // A site holding another value ends the walk without consuming a draw.
      j = (s + 1) % len;
      while (spins[j] == oldv) begin
        if (!draw_joins()) break;
        flip_site(j, oldv, newv);
        right++;
        j = (j + 1) % len;
      end
      j = (s + len - 1) % len;
      while (spins[j] == oldv) begin
        if (!draw_joins()) break;
        flip_site(j, oldv, newv);
        left++;
        j = (j + len - 1) % len;
      end
      total      = 1 + right + left;
      first      = (total >= len) ? s : (s + len - left) % len;
      e.cl_start = SiteW'(first);
      e.cl_len   = LenW'(total);
      e.old_val  = ValW'(oldv);
      e.new_val  = ValW'(newv);
      e.old_cnt  = counts[oldv];
      e.new_cnt  = counts[newv];
      expected_flips.push_back(e);
    endfunction

    function void compare_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
    endfunction

    function void check_flip(flip_t got);
      flip_t want;
      if (expected_flips.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual start %0d length %0d",
                 $time, got.cl_start, got.cl_len);
        return;
      end
      want = expected_flips.pop_front();
      compare_field("cluster_start", want.cl_start, got.cl_start);
      compare_field("cluster_length", want.cl_len, got.cl_len);
      compare_field("old_value", want.old_val, got.old_val);
      compare_field("new_value", want.new_val, got.new_val);
      compare_field("old_value_count", want.old_cnt, got.old_cnt);
      compare_field("new_value_count", want.new_cnt, got.new_cnt);
    endfunction
  endclass

  // Every input has a known value from time zero onwards.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic [SiteW-1:0]    seed_site_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                busy_o;
  logic                cfg_ready_o;
  logic                done_o;
  logic [SiteW-1:0]    cluster_start_o;
  logic [LenW-1:0]     cluster_length_o;
  logic [ValW-1:0]     old_value_o;
  logic [ValW-1:0]     new_value_o;
  logic [CntW-1:0]     old_value_count_o;
  logic [CntW-1:0]     new_value_count_o;

  flip_scoreboard sb;
  int unsigned    cycles = 0;

  ring_spin_cluster_flip DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .seed_site_i      (seed_site_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .cluster_start_o  (cluster_start_o),
    .cluster_length_o (cluster_length_o),
    .old_value_o      (old_value_o),
    .new_value_o      (new_value_o),
    .old_value_count_o(old_value_count_o),
    .new_value_count_o(new_value_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d updates outstanding", $time, sb.expected_flips.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, where the block's outputs still hold
  // the values of the cycle that is ending. A result is checked before a seed accepted at the
  // same edge is noted, although the queue order would make either order safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_flip({cluster_start_o, cluster_length_o, old_value_o, new_value_o,
                       old_value_count_o, new_value_count_o});
      end
      if (cfg_valid_i && cfg_ready_o) sb.apply_config(cfg_index_i, cfg_data_i);
      if (start_i && !busy_o) sb.note_seed(seed_site_i);
    end
  end

  // Offer one seed and wait for the transaction. The start line stays high when the next
  // seed follows at once, so it is never lowered and raised within the same time step.
  task automatic send_seed(input logic [SiteW-1:0] seed, input int unsigned gap);
    start_i     <= 1'b1;
    seed_site_i <= seed;
    do @(posedge clk_i); while (busy_o);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender back until every queued update has been reported, then wait settle more
  // edges so the block is certainly idle. It first waits for a rising edge, so that a seed
  // accepted at the edge just gone has been noted by the monitor before the queue is read.
  task automatic wait_flips_done(input int unsigned settle);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_flips.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // One register write. Valid is dropped for a cycle afterwards, so that back-to-back
  // writes never lower and raise it in the same step.
  task automatic write_setting(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random setup for one phase. The upper data bits are random to show they are dropped,
  // geometry is mostly in range but sometimes beyond it on either side, and the threshold
  // leans towards high values so that clusters grow long.
  task automatic randomise_setup();
    logic [CfgDataW-1:0] data;
    int unsigned         pick;
    if ($urandom_range(0, 1) == 1) begin
      pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      data = ($urandom & ~CfgDataW'(31)) | CfgDataW'(pick);
      write_setting(RegRingLength, data);
    end
    if ($urandom_range(0, 1) == 1) begin
      pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8);
      data = ($urandom & ~CfgDataW'(15)) | CfgDataW'(pick);
      write_setting(RegNumStates, data);
    end
    case ($urandom_range(0, 3))
      0: pick = $urandom_range(0, 65535);
      1: pick = 65535;
      default: pick = $urandom_range(40000, 65535);
    endcase
    data = ($urandom & ~CfgDataW'(16'hFFFF)) | CfgDataW'(pick);
    write_setting(RegThreshold, data);
    write_setting(RegRngSeed, ($urandom_range(0, 9) == 0) ? '0 : CfgDataW'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      write_setting(CfgIdxW'($urandom_range(int'(RegRngSeed) + 1, int'(RegUnusedTop))),
                    $urandom);
    end
  endtask

  initial begin
    int unsigned phase, n, idle_pct, gap;
    sb = new();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part. The reset setup first: sixteen sites, three values, a high threshold,
    // at both ends of the ring and in the middle.
    send_seed(SiteW'(0), 0);
    send_seed(SiteW'(15), 0);
    send_seed(SiteW'(7), 0);

    // A zero ring length acts as two sites, so both neighbours are the same site; once it has
    // joined, the leftward walk stops on it without a draw. Seeds beyond the ring wrap round.
    wait_flips_done(3);
    write_setting(RegRingLength, '0);
    send_seed(SiteW'(0), 0);
    send_seed(SiteW'(1), 0);
    send_seed(SiteW'(15), 0);
    send_seed(SiteW'(14), 0);

    // Oversized length and a value count of zero clamp to sixteen sites and two values. With
    // the highest threshold and a zero generator seed the whole ring tends to flip at once.
    wait_flips_done(3);
    write_setting(RegRingLength, CfgDataW'(31));
    write_setting(RegNumStates, '0);
    write_setting(RegThreshold, CfgDataW'(16'hFFFF));
    write_setting(RegRngSeed, '0);
    send_seed(SiteW'(3), 0);
    send_seed(SiteW'(8), 0);

    // Value count fifteen acts as eight. With a zero threshold nothing joins, so one site
    // steps through every value and wraps from the top one back to zero.
    wait_flips_done(3);
    write_setting(RegNumStates, CfgDataW'(15));
    write_setting(RegThreshold, '0);
    write_setting(RegRngSeed, '1);
    for (n = 0; n < 9; n++) send_seed(SiteW'(5), 0);

    // A write to an unused index must leave the registers and the generator alone.
    wait_flips_done(3);
    write_setting(RegUnusedTop, '1);
    send_seed(SiteW'(6), 0);

    // A five-site ring with seeds, two of which need reducing.
    wait_flips_done(3);
    write_setting(RegRingLength, CfgDataW'(5));
    write_setting(RegThreshold, CfgDataW'(50000));
    send_seed(SiteW'(15), 0);
    send_seed(SiteW'(9), 0);
    send_seed(SiteW'(4), 0);

    // Random part: eight phases of fifty seeds, each with its own setup. The phases rotate
    // through no idling, a sender idle most of the time, and a sender idle now and then.
    // Occasionally the sender also holds back until every update has been reported.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 70;
        default: idle_pct = 17;
      endcase
      wait_flips_done(3);
      randomise_setup();
      for (n = 0; n < 50; n++) begin
        gap = 0;
        while (gap < 24 && $urandom_range(0, 99) < idle_pct) gap++;
        send_seed(SiteW'($urandom_range(0, 15)), gap);
        if ($urandom_range(0, 99) < 4) wait_flips_done(1);
      end
    end

    // Let the last updates arrive and give the block time to show any stray result.
    wait_flips_done(25);
    if (sb.errors == 0 && sb.expected_flips.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
